FILE: design/qsc_pkg.sv
package qsc_pkg;

    localparam int DUR_W = 20;
    localparam int VAL_W = 32;
    localparam int COEF_W = 48;
    localparam int QBITS = 48;
    localparam int NUM_W = 77;
    localparam int MAG_W = 76;
    localparam int DEN3_W = 60;
    localparam int DEN4_W = 80;
    localparam int DEN5_W = 100;
    localparam int SH3 = 15;
    localparam int SH4 = 31;
    localparam int SH5 = 47;
    localparam int NUM3_W = MAG_W + SH3;
    localparam int NUM4_W = MAG_W + SH4;
    localparam int NUM5_W = MAG_W + SH5;

    localparam logic [1:0] ADDR_MIN_INTERVAL = 2'd0;

    typedef struct packed {
        logic invalid;
        logic neg3;
        logic neg4;
        logic neg5;
        logic signed [COEF_W-1:0] c0;
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
    } side_t;

endpackage

FILE: design/qsc_if.sv
interface qsc_seg_if;
    logic valid;
    logic ready;
    logic [qsc_pkg::DUR_W-1:0] duration;
    logic signed [qsc_pkg::VAL_W-1:0] start_pos;
    logic signed [qsc_pkg::VAL_W-1:0] start_vel;
    logic signed [qsc_pkg::VAL_W-1:0] start_acc;
    logic signed [qsc_pkg::VAL_W-1:0] end_pos;
    logic signed [qsc_pkg::VAL_W-1:0] end_vel;
    logic signed [qsc_pkg::VAL_W-1:0] end_acc;

    modport source (output valid, duration, start_pos, start_vel, start_acc,
                    end_pos, end_vel, end_acc, input ready);
    modport sink (input valid, duration, start_pos, start_vel, start_acc,
                  end_pos, end_vel, end_acc, output ready);
endinterface

interface qsc_coef_if;
    logic valid;
    logic ready;
    logic signed [qsc_pkg::COEF_W-1:0] coef_0;
    logic signed [qsc_pkg::COEF_W-1:0] coef_1;
    logic signed [qsc_pkg::COEF_W-1:0] coef_2;
    logic signed [qsc_pkg::COEF_W-1:0] coef_3;
    logic signed [qsc_pkg::COEF_W-1:0] coef_4;
    logic signed [qsc_pkg::COEF_W-1:0] coef_5;
    logic invalid_interval;
    logic saturated;

    modport source (output valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                    invalid_interval, saturated, input ready);
    modport sink (input valid, coef_0, coef_1, coef_2, coef_3, coef_4, coef_5,
                  invalid_interval, saturated, output ready);
endinterface

FILE: design/qsc_prep.sv
module qsc_prep (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [qsc_pkg::DUR_W-1:0] duration,
    input  logic signed [qsc_pkg::VAL_W-1:0] start_pos,
    input  logic signed [qsc_pkg::VAL_W-1:0] start_vel,
    input  logic signed [qsc_pkg::VAL_W-1:0] start_acc,
    input  logic signed [qsc_pkg::VAL_W-1:0] end_pos,
    input  logic signed [qsc_pkg::VAL_W-1:0] end_vel,
    input  logic signed [qsc_pkg::VAL_W-1:0] end_acc,
    input  logic [qsc_pkg::DUR_W-1:0] min_interval,
    output logic out_valid,
    output qsc_pkg::side_t side,
    output logic [qsc_pkg::NUM3_W-1:0] num3,
    output logic [qsc_pkg::NUM4_W-1:0] num4,
    output logic [qsc_pkg::NUM5_W-1:0] num5,
    output logic [qsc_pkg::DEN3_W-1:0] den3,
    output logic [qsc_pkg::DEN4_W-1:0] den4,
    output logic [qsc_pkg::DEN5_W-1:0] den5
);

    localparam int DW = qsc_pkg::DUR_W;
    localparam int VW = qsc_pkg::VAL_W;
    localparam int NW = qsc_pkg::NUM_W;
    localparam int MW = qsc_pkg::MAG_W;

    logic [4:0] vld_reg;

    // stage 1: input word
    logic [DW-1:0] d1_reg;
    logic signed [VW-1:0] p1_reg, v1_reg, a1_reg, p2_reg, v2_reg, a2_reg;

    // stage 2: linear combinations and d squared
    logic [DW-1:0] d2_reg;
    logic [2*DW-1:0] dsq_reg;
    logic signed [34:0] ca_reg [3];
    logic signed [36:0] cv_reg [3];
    logic signed [37:0] cp_reg [3];
    qsc_pkg::side_t side2_reg;

    // stage 3: products
    logic [DW-1:0] d3_reg;
    logic [qsc_pkg::DEN3_W-1:0] den3_3_reg;
    logic signed [NW-1:0] ta_reg [3];
    logic signed [57:0] tv_reg [3];
    logic signed [37:0] cp3_reg [3];
    qsc_pkg::side_t side3_reg;

    // stage 4: numerators
    logic [DW-1:0] d4_reg;
    logic [qsc_pkg::DEN3_W-1:0] den3_4_reg;
    logic [qsc_pkg::DEN4_W-1:0] den4_4_reg;
    logic signed [NW-1:0] n_reg [3];
    qsc_pkg::side_t side4_reg;

    // stage 5: magnitudes and last denominator
    logic [qsc_pkg::DEN3_W-1:0] den3_5_reg;
    logic [qsc_pkg::DEN4_W-1:0] den4_5_reg;
    logic [qsc_pkg::DEN5_W-1:0] den5_5_reg;
    logic [qsc_pkg::NUM3_W-1:0] num3_reg;
    logic [qsc_pkg::NUM4_W-1:0] num4_reg;
    logic [qsc_pkg::NUM5_W-1:0] num5_reg;
    qsc_pkg::side_t side5_reg;

    logic signed [32:0] dpos;
    logic signed [VW-1:0] half_acc;
    logic [MW-1:0] mag [3];

    assign dpos = 33'(p1_reg) - 33'(p2_reg);
    assign half_acc = $signed(a1_reg + VW'(a1_reg[VW-1])) >>> 1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = n_reg[k][NW-1] ? MW'(-n_reg[k]) : MW'(n_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid)
            begin
                d1_reg <= duration;
                p1_reg <= start_pos;
                v1_reg <= start_vel;
                a1_reg <= start_acc;
                p2_reg <= end_pos;
                v2_reg <= end_vel;
                a2_reg <= end_acc;
            end

            d2_reg <= d1_reg;
            dsq_reg <= (2*DW)'(d1_reg) * (2*DW)'(d1_reg);
            ca_reg[0] <= 35'(a1_reg) * 35'sd3 - 35'(a2_reg);
            ca_reg[1] <= 35'(a1_reg) * 35'sd3 - 35'(a2_reg) * 35'sd2;
            ca_reg[2] <= 35'(a1_reg) - 35'(a2_reg);
            cv_reg[0] <= 37'(v2_reg) * 37'sd8 + 37'(v1_reg) * 37'sd12;
            cv_reg[1] <= 37'(v2_reg) * 37'sd14 + 37'(v1_reg) * 37'sd16;
            cv_reg[2] <= 37'(v2_reg) * 37'sd6 + 37'(v1_reg) * 37'sd6;
            cp_reg[0] <= 38'(dpos) * 38'sd20;
            cp_reg[1] <= 38'(dpos) * 38'sd30;
            cp_reg[2] <= 38'(dpos) * 38'sd12;
            side2_reg.invalid <= (d1_reg <= min_interval);
            side2_reg.neg3 <= 1'b0;
            side2_reg.neg4 <= 1'b0;
            side2_reg.neg5 <= 1'b0;
            side2_reg.c0 <= qsc_pkg::COEF_W'(p1_reg);
            side2_reg.c1 <= qsc_pkg::COEF_W'(v1_reg);
            side2_reg.c2 <= qsc_pkg::COEF_W'(half_acc);

            d3_reg <= d2_reg;
            den3_3_reg <= qsc_pkg::DEN3_W'(dsq_reg) * qsc_pkg::DEN3_W'(d2_reg);
            for (int k = 0; k < 3; k++)
            begin
                ta_reg[k] <= NW'(ca_reg[k]) * NW'($signed({1'b0, dsq_reg}));
                tv_reg[k] <= 58'(cv_reg[k]) * 58'($signed({1'b0, d2_reg}));
                cp3_reg[k] <= cp_reg[k];
            end
            side3_reg <= side2_reg;

            d4_reg <= d3_reg;
            den3_4_reg <= den3_3_reg;
            den4_4_reg <= qsc_pkg::DEN4_W'(den3_3_reg) * qsc_pkg::DEN4_W'(d3_reg);
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= ta_reg[k] + (NW'(tv_reg[k]) <<< 16) + (NW'(cp3_reg[k]) <<< 32);
            end
            side4_reg <= side3_reg;

            den3_5_reg <= den3_4_reg;
            den4_5_reg <= den4_4_reg;
            den5_5_reg <= qsc_pkg::DEN5_W'(den4_4_reg) * qsc_pkg::DEN5_W'(d4_reg);
            num3_reg <= qsc_pkg::NUM3_W'(mag[0]) << qsc_pkg::SH3;
            num4_reg <= qsc_pkg::NUM4_W'(mag[1]) << qsc_pkg::SH4;
            num5_reg <= qsc_pkg::NUM5_W'(mag[2]) << qsc_pkg::SH5;
            side5_reg <= {side4_reg.invalid, ~n_reg[0][NW-1], n_reg[1][NW-1],
                          ~n_reg[2][NW-1], side4_reg.c0, side4_reg.c1, side4_reg.c2};
        end
    end

    assign out_valid = vld_reg[4];
    assign side = side5_reg;
    assign num3 = num3_reg;
    assign num4 = num4_reg;
    assign num5 = num5_reg;
    assign den3 = den3_5_reg;
    assign den4 = den4_5_reg;
    assign den5 = den5_5_reg;

endmodule

FILE: design/qsc_div_cell.sv
module qsc_div_cell #(
    parameter int DW = 60
) (
    input  logic clk,
    input  logic en,
    input  logic [DW-1:0] rem_i,
    input  logic [DW-1:0] den_i,
    input  logic [qsc_pkg::QBITS-1:0] bits_i,
    input  logic [qsc_pkg::QBITS-1:0] quo_i,
    input  logic ovf_i,
    output logic [DW-1:0] rem_o,
    output logic [DW-1:0] den_o,
    output logic [qsc_pkg::QBITS-1:0] bits_o,
    output logic [qsc_pkg::QBITS-1:0] quo_o,
    output logic ovf_o
);

    localparam int QB = qsc_pkg::QBITS;

    logic [DW-1:0] rem_reg, den_reg;
    logic [QB-1:0] bits_reg, quo_reg;
    logic ovf_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic ge;

    assign trial = {rem_i, bits_i[QB-1]};
    assign diff = trial - {1'b0, den_i};
    assign ge = trial >= {1'b0, den_i};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            den_reg <= den_i;
            bits_reg <= {bits_i[QB-2:0], 1'b0};
            quo_reg <= {quo_i[QB-2:0], ge};
            ovf_reg <= ovf_i;
        end
    end

    assign rem_o = rem_reg;
    assign den_o = den_reg;
    assign bits_o = bits_reg;
    assign quo_o = quo_reg;
    assign ovf_o = ovf_reg;

endmodule

FILE: design/qsc_div.sv
module qsc_div #(
    parameter int NW = 91,
    parameter int DW = 60
) (
    input  logic clk,
    input  logic en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [qsc_pkg::QBITS-1:0] quo,
    output logic ovf
);

    localparam int QB = qsc_pkg::QBITS;
    localparam int HW = NW - QB;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_w [QB+1];
    logic [DW-1:0] den_w [QB+1];
    logic [QB-1:0] bits_w [QB+1];
    logic [QB-1:0] quo_w [QB+1];
    logic ovf_w [QB+1];

    // quotient wider than 48 bits is known at entry
    assign ovf_w[0] = CW'(num[NW-1:QB]) >= CW'(den);
    assign rem_w[0] = DW'(num[NW-1:QB]);
    assign den_w[0] = den;
    assign bits_w[0] = num[QB-1:0];
    assign quo_w[0] = '0;

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        qsc_div_cell #(.DW(DW)) u_cell (
            .clk    (clk),
            .en     (en),
            .rem_i  (rem_w[i]),
            .den_i  (den_w[i]),
            .bits_i (bits_w[i]),
            .quo_i  (quo_w[i]),
            .ovf_i  (ovf_w[i]),
            .rem_o  (rem_w[i+1]),
            .den_o  (den_w[i+1]),
            .bits_o (bits_w[i+1]),
            .quo_o  (quo_w[i+1]),
            .ovf_o  (ovf_w[i+1])
        );
    end

    assign quo = quo_w[QB];
    assign ovf = ovf_w[QB];

endmodule

FILE: design/quintic_segment_coefficients_top.sv
// channel | dir | word
// seg     | in  | duration, start/end position, velocity, acceleration
// coef    | out | coef_0..coef_5, invalid_interval, saturated
// apb     | cfg | min_interval at address 0
//
// one segment per cycle unless a result waits on coef; 5 arithmetic stages, a row of 48
// restoring division cells (one quotient bit each), one output register
// the whole pipeline holds while a result waits on coef
// rst_n clears the valid bits and min_interval
module quintic_segment_coefficients_top (
    input  logic clk,
    input  logic rst_n,
    qsc_seg_if.sink seg,
    qsc_coef_if.source coef,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    localparam int QB = qsc_pkg::QBITS;
    localparam int CWD = qsc_pkg::COEF_W;
    localparam logic [CWD-1:0] POS_LIM = {1'b0, {(CWD-1){1'b1}}};
    localparam logic [CWD-1:0] NEG_LIM = {1'b1, {(CWD-1){1'b0}}};

    logic [qsc_pkg::DUR_W-1:0] min_reg;
    logic adv;
    logic out_valid_reg;

    logic prep_valid;
    qsc_pkg::side_t prep_side;
    logic [qsc_pkg::NUM3_W-1:0] num3;
    logic [qsc_pkg::NUM4_W-1:0] num4;
    logic [qsc_pkg::NUM5_W-1:0] num5;
    logic [qsc_pkg::DEN3_W-1:0] den3;
    logic [qsc_pkg::DEN4_W-1:0] den4;
    logic [qsc_pkg::DEN5_W-1:0] den5;
    logic [QB-1:0] q3, q4, q5;
    logic ovf3, ovf4, ovf5;

    logic vld_reg [QB];
    qsc_pkg::side_t side_reg [QB];

    logic signed [CWD-1:0] c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic inv_reg, sat_reg;

    logic [CWD-1:0] f3, f4, f5;
    logic s3, s4, s5;

    function automatic logic [CWD:0] fit(input logic [QB-1:0] q, input logic ovf,
                                         input logic neg);
        logic [CWD-1:0] lim;
        logic sat;
        logic [CWD-1:0] v;
        lim = neg ? NEG_LIM : POS_LIM;
        sat = ovf || (CWD'(q) > lim);
        v = sat ? lim : CWD'(q);
        return {sat, neg ? -v : v};
    endfunction

    assign adv = !out_valid_reg || coef.ready;
    assign seg.ready = adv;
    assign pready = 1'b1;
    assign prdata = (paddr == qsc_pkg::ADDR_MIN_INTERVAL) ? 32'(min_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == qsc_pkg::ADDR_MIN_INTERVAL)
        begin
            min_reg <= pwdata[qsc_pkg::DUR_W-1:0];
        end
    end

    qsc_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (seg.valid),
        .duration     (seg.duration),
        .start_pos    (seg.start_pos),
        .start_vel    (seg.start_vel),
        .start_acc    (seg.start_acc),
        .end_pos      (seg.end_pos),
        .end_vel      (seg.end_vel),
        .end_acc      (seg.end_acc),
        .min_interval (min_reg),
        .out_valid    (prep_valid),
        .side         (prep_side),
        .num3         (num3),
        .num4         (num4),
        .num5         (num5),
        .den3         (den3),
        .den4         (den4),
        .den5         (den5)
    );

    qsc_div #(.NW(qsc_pkg::NUM3_W), .DW(qsc_pkg::DEN3_W)) u_div3 (
        .clk (clk), .en (adv), .num (num3), .den (den3), .quo (q3), .ovf (ovf3)
    );

    qsc_div #(.NW(qsc_pkg::NUM4_W), .DW(qsc_pkg::DEN4_W)) u_div4 (
        .clk (clk), .en (adv), .num (num4), .den (den4), .quo (q4), .ovf (ovf4)
    );

    qsc_div #(.NW(qsc_pkg::NUM5_W), .DW(qsc_pkg::DEN5_W)) u_div5 (
        .clk (clk), .en (adv), .num (num5), .den (den5), .quo (q5), .ovf (ovf5)
    );

    // side word travels alongside the division cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QB; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= prep_valid;
            for (int i = 1; i < QB; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= prep_side;
            for (int i = 1; i < QB; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign {s3, f3} = fit(q3, ovf3, side_reg[QB-1].neg3);
    assign {s4, f4} = fit(q4, ovf4, side_reg[QB-1].neg4);
    assign {s5, f5} = fit(q5, ovf5, side_reg[QB-1].neg5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[QB-1])
        begin
            if (side_reg[QB-1].invalid)
            begin
                c0_reg <= '0;
                c1_reg <= '0;
                c2_reg <= '0;
                c3_reg <= '0;
                c4_reg <= '0;
                c5_reg <= '0;
                inv_reg <= 1'b1;
                sat_reg <= 1'b0;
            end
            else
            begin
                c0_reg <= side_reg[QB-1].c0;
                c1_reg <= side_reg[QB-1].c1;
                c2_reg <= side_reg[QB-1].c2;
                c3_reg <= f3;
                c4_reg <= f4;
                c5_reg <= f5;
                inv_reg <= 1'b0;
                sat_reg <= s3 | s4 | s5;
            end
        end
    end

    assign coef.valid = out_valid_reg;
    assign coef.coef_0 = c0_reg;
    assign coef.coef_1 = c1_reg;
    assign coef.coef_2 = c2_reg;
    assign coef.coef_3 = c3_reg;
    assign coef.coef_4 = c4_reg;
    assign coef.coef_5 = c5_reg;
    assign coef.invalid_interval = inv_reg;
    assign coef.saturated = sat_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && coef.invalid_interval |->
            !coef.saturated && coef.coef_0 == 0 && coef.coef_5 == 0)
        else $error("rejected segment with nonzero word");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && !coef.ready |-> !seg.ready)
        else $error("input taken while result stalled");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && !coef.ready |=> coef.valid && $stable(coef.coef_3))
        else $error("stalled result changed");

endmodule

FILE: test/tb_quintic_segment_coefficients_top.sv
module tb_quintic_segment_coefficients_top;

    localparam int DW = qsc_pkg::DUR_W;
    localparam int VW = qsc_pkg::VAL_W;
    localparam int CW = qsc_pkg::COEF_W;

    typedef struct packed {
        logic [5:0][CW-1:0] c;
        logic               inv;
        logic               sat;
    } coef_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    qsc_seg_if seg_bus ();
    qsc_coef_if coef_bus ();

    quintic_segment_coefficients_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .seg(seg_bus.sink),
        .coef(coef_bus.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    coef_word_t coef_expected[$];
    logic [DW-1:0] min_interval_model;
    int mismatches;
    int cycles;
    bit idling_on;
    int stall_left;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 70;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CW-1:0] fit_coef(input logic signed [255:0] num,
                                               input bit flip, input int sh,
                                               input logic [255:0] den, inout bit sat);
        logic [255:0] mag;
        logic [255:0] q;
        logic [255:0] lim;
        bit neg;
        neg = (num < 0) != flip;
        mag = (num < 0) ? -num : num;
        q = (mag << sh) / den;
        lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 1);
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return CW'(neg ? (-q) : q);
    endfunction

    function automatic coef_word_t quintic_coefs(input logic [DW-1:0] dur,
                                                 input logic signed [VW-1:0] p1i,
                                                 input logic signed [VW-1:0] v1i,
                                                 input logic signed [VW-1:0] a1i,
                                                 input logic signed [VW-1:0] p2i,
                                                 input logic signed [VW-1:0] v2i,
                                                 input logic signed [VW-1:0] a2i);
        coef_word_t w;
        logic signed [255:0] p1, v1, a1, p2, v2, a2, d, d2, dv, dp, n3, n4, n5;
        bit sat;
        w = '0;
        sat = 1'b0;
        if (dur <= min_interval_model)
        begin
            w.inv = 1'b1;
            return w;
        end
        p1 = 256'(p1i); v1 = 256'(v1i); a1 = 256'(a1i);
        p2 = 256'(p2i); v2 = 256'(v2i); a2 = 256'(a2i);
        d = {236'd0, dur};
        d2 = d * d;
        dv = d << 16;
        dp = 256'sd1 <<< 32;
        n3 = (3 * a1 - a2) * d2 + (8 * v2 + 12 * v1) * dv + 20 * (p1 - p2) * dp;
        n4 = (3 * a1 - 2 * a2) * d2 + (14 * v2 + 16 * v1) * dv + 30 * (p1 - p2) * dp;
        n5 = (a1 - a2) * d2 + (6 * v2 + 6 * v1) * dv + 12 * (p1 - p2) * dp;
        w.c[0] = CW'(p1);
        w.c[1] = CW'(v1);
        w.c[2] = CW'(a1 / 2);
        w.c[3] = fit_coef(n3, 1'b1, qsc_pkg::SH3, d2 * d, sat);
        w.c[4] = fit_coef(n4, 1'b0, qsc_pkg::SH4, d2 * d2, sat);
        w.c[5] = fit_coef(n5, 1'b1, qsc_pkg::SH5, d2 * d2 * d, sat);
        w.sat = sat;
        return w;
    endfunction

    // stimulus side
    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seg_bus.valid = 1'b0;
        seg_bus.duration = '0;
        seg_bus.start_pos = '0;
        seg_bus.start_vel = '0;
        seg_bus.start_acc = '0;
        seg_bus.end_pos = '0;
        seg_bus.end_vel = '0;
        seg_bus.end_acc = '0;
        coef_bus.ready = 1'b0;
    end

    task automatic send_segment(input logic [DW-1:0] dur,
                                input logic [VW-1:0] p1, input logic [VW-1:0] v1,
                                input logic [VW-1:0] a1, input logic [VW-1:0] p2,
                                input logic [VW-1:0] v2, input logic [VW-1:0] a2);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            seg_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        seg_bus.valid <= 1'b1;
        seg_bus.duration <= dur;
        seg_bus.start_pos <= p1;
        seg_bus.start_vel <= v1;
        seg_bus.start_acc <= a1;
        seg_bus.end_pos <= p2;
        seg_bus.end_vel <= v2;
        seg_bus.end_acc <= a2;
        do
            @(posedge clk);
        while (!seg_bus.ready);
        coef_expected.insert(coef_expected.size(), quintic_coefs(dur, p1, v1, a1, p2, v2, a2));
        @(negedge clk);
    endtask

    task automatic settle_idle();
        seg_bus.valid <= 1'b0;
        while (coef_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_min_interval(input logic [DW-1:0] value);
        settle_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= qsc_pkg::ADDR_MIN_INTERVAL;
        pwdata <= {12'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        min_interval_model = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[DW-1:0] !== value)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("min_interval readback: expected %h actual %h", value, prdata);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return $signed($urandom_range(0, 8191)) - 4096;
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_duration();
        case ($urandom_range(0, 5))
            0: return DW'($urandom_range(0, 64));
            1: return DW'($urandom_range(1 << 14, 1 << 18));
            2: return DW'(min_interval_model + $urandom_range(0, 2) - 1);
            3: return $urandom_range(0, 1) ? 20'hfffff : DW'(20'hffff0 + $urandom_range(0, 15));
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_segment(pick_duration(), pick_value(), pick_value(), pick_value(),
                         pick_value(), pick_value(), pick_value());
    endtask

    task automatic test_directed();
        send_segment(20'd0, 32'h12345678, 32'h1, 32'h3, 32'h0, 32'h0, 32'h0);
        send_segment(20'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_segment(20'd1, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_segment(20'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000);
        send_segment(20'hfffff, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_segment(20'hfffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000);
        send_segment(20'h10000, 32'h0, 32'h0, 32'hffffffff, 32'h10000, 32'h0, 32'h0);
        send_segment(20'h10000, 32'h10000, 32'h0, 32'hfffffffd, 32'h0, 32'h0, 32'h1);
        send_segment(20'h08000, 32'hffff0000, 32'h20000, 32'h5, 32'h30000, 32'hfffe0000,
                     32'hfffffffb);
        send_segment(20'h00100, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0);
        send_segment(20'h00001, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0);
        send_segment(20'h7ffff, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                     32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
        send_segment(20'h80000, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                     32'h55555555, 32'haaaaaaaa, 32'h55555555);
    endtask

    task automatic test_threshold();
        write_min_interval(20'h04000);
        send_segment(20'h03fff, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_segment(20'h04000, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_segment(20'h04001, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        write_min_interval(20'hfffff);
        send_segment(20'hfffff, 32'h7fffffff, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        send_random(20);
        write_min_interval(20'hffffe);
        send_segment(20'hfffff, 32'h7fffffff, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        send_segment(20'hffffe, 32'h7fffffff, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
    endtask

    task automatic test_random();
        write_min_interval(20'd0);
        send_random(500);
        write_min_interval(DW'($urandom_range(1, 1 << 16)));
        send_random(300);
        write_min_interval(DW'($urandom));
        send_random(150);
        write_min_interval(20'd0);
        send_random(150);
        idling_on = 1'b0;
        send_random(250);
    endtask

    initial
    begin
        rst_n = 1'b0;
        idling_on = 1'b1;
        min_interval_model = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_threshold();
        test_random();
        settle_idle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // sink side stalls
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                coef_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                coef_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end
            else
                coef_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        coef_word_t want;
        coef_word_t got;
        bit bad;
        if (rst_n && coef_bus.valid && coef_bus.ready)
        begin
            got.c[0] = coef_bus.coef_0;
            got.c[1] = coef_bus.coef_1;
            got.c[2] = coef_bus.coef_2;
            got.c[3] = coef_bus.coef_3;
            got.c[4] = coef_bus.coef_4;
            got.c[5] = coef_bus.coef_5;
            got.inv = coef_bus.invalid_interval;
            got.sat = coef_bus.saturated;
            if (coef_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h", got);
            end
            else
            begin
                want = coef_expected.pop_front();
                bad = (want.inv !== got.inv) || (want.sat !== got.sat);
                for (int k = 0; k < 6; k++)
                    if (want.c[k] !== got.c[k])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("coef mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
